FILE: rtl/prrts_pkg.sv
// Shared types and constants for the priority round-robin thread scheduler.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package prrts_pkg;

    typedef struct packed {
        logic [2:0]  command;
        logic [5:0]  slot;
        logic [7:0]  priority_req;
        logic [31:0] wait_object;
        logic        timed;
        logic [47:0] deadline;
        logic [47:0] now;
    } t_sched_in;

    typedef struct packed {
        logic [5:0]  current_thread;
        logic        switched;
        logic        idle;
        logic [22:0] timer_usec;
        logic        status;
    } t_sched_out;

    // one thread slot as it travels round the ring
    typedef struct packed {
        logic        valid;
        logic [2:0]  st;
        logic [7:0]  prio;
        logic [31:0] obj;
        logic [47:0] dl;
    } t_slot_rec;

    localparam logic [2:0] CMD_ADD     = 3'd0;
    localparam logic [2:0] CMD_REMOVE  = 3'd1;
    localparam logic [2:0] CMD_SETPRIO = 3'd2;
    localparam logic [2:0] CMD_WAIT    = 3'd3;
    localparam logic [2:0] CMD_WAKEALL = 3'd4;
    localparam logic [2:0] CMD_WAKE1   = 3'd5;
    localparam logic [2:0] CMD_TICK    = 3'd6;
    localparam logic [2:0] CMD_YIELD   = 3'd7;

    localparam logic [2:0] ST_STOP  = 3'd0;
    localparam logic [2:0] ST_RUN   = 3'd1;
    localparam logic [2:0] ST_WAIT  = 3'd2;
    localparam logic [2:0] ST_TWAIT = 3'd3;

    localparam logic [47:0] TIMER_MIN     = 48'd20;
    localparam logic [47:0] TIMER_MAX     = 48'd4194304;
    localparam logic [47:0] NO_WAKE_USEC  = 48'd10000000;
    localparam logic [22:0] QUANTUM_RESET = 23'd10000;

endpackage

`default_nettype wire

FILE: rtl/prrts_cell.sv
// One thread slot of the scheduler ring: holds the slot and takes its
// neighbour's slot on every shift. Depends on prrts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module prrts_cell
    import prrts_pkg::*;
#(
    parameter bit RESET_VALID = 1'b0
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_shift,
    input  wire t_slot_rec i_d,
    output t_slot_rec      o_q
);

    logic        r_valid;
    logic [2:0]  r_st;
    logic [7:0]  r_prio;
    logic [31:0] r_obj;
    logic [47:0] r_dl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= RESET_VALID;
            r_st    <= RESET_VALID ? ST_RUN : ST_STOP;
            r_prio  <= 8'd0;
        end else if (i_shift) begin
            r_valid <= i_d.valid;
            r_st    <= i_d.st;
            r_prio  <= i_d.prio;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_obj <= i_d.obj;
            r_dl  <= i_d.dl;
        end
    end

    assign o_q = '{valid: r_valid, st: r_st, prio: r_prio, obj: r_obj, dl: r_dl};

endmodule

`default_nettype wire

FILE: rtl/prrts_ring.sv
// Ring of thread slot cells; slot at the head is seen by the sequencer and
// the edited slot re-enters at the tail. Depends on prrts_pkg, prrts_cell.
`timescale 1ns / 1ps
`default_nettype none

module prrts_ring
    import prrts_pkg::*;
#(
    parameter int THREADS = 64
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_shift,
    input  wire t_slot_rec i_tail,
    output t_slot_rec      o_head
);

    t_slot_rec w_q [THREADS];

    for (genvar k = 0; k < THREADS; k++) begin : g_cell
        t_slot_rec w_d;
        if (k == THREADS - 1) begin : g_last
            assign w_d = i_tail;
        end else begin : g_mid
            assign w_d = w_q[k+1];
        end
        prrts_cell #(.RESET_VALID(k == 0)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (i_shift),
            .i_d     (w_d),
            .o_q     (w_q[k])
        );
    end

    assign o_head = w_q[0];

endmodule

`default_nettype wire

FILE: rtl/priority_round_robin_thread_scheduler_top.sv
// Priority round-robin thread scheduler: top level with command sequencer.
// Depends on prrts_pkg, prrts_ring.
`timescale 1ns / 1ps
`default_nettype none

// Thread slots circulate through a ring of cells, one slot reaching the head
// each cycle while a pass runs. A command is taken when i_start is high and
// o_busy low. Every command makes one pass of the ring to apply its edit; wake
// single adds a second pass to wake the chosen waiter; a reschedule adds one
// more pass to expire timed waits and pick the next thread. The decision and
// timer work follow in states S_DEC and S_TIM. The result beat appears on
// o_res for one cycle with o_done high and cannot be held off. i_cfg_we
// writes the quantum.

module priority_round_robin_thread_scheduler_top
    import prrts_pkg::*;
#(
    parameter int THREADS = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire t_sched_in   i_cmd,
    output logic             o_busy,
    output logic             o_done,
    output t_sched_out       o_res,
    input  wire logic        i_cfg_we,
    input  wire logic [22:0] i_cfg_wdata
);

    localparam int CW = (THREADS > 1) ? $clog2(THREADS) : 1;
    localparam logic [CW-1:0] LAST = CW'(THREADS - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PA   = 3'd1;
    localparam logic [2:0] S_ACT  = 3'd2;
    localparam logic [2:0] S_PB   = 3'd3;
    localparam logic [2:0] S_CHK  = 3'd4;
    localparam logic [2:0] S_PR   = 3'd5;
    localparam logic [2:0] S_DEC  = 3'd6;
    localparam logic [2:0] S_TIM  = 3'd7;

    logic [2:0]    r_state;
    logic [CW-1:0] r_idx;
    t_sched_in     r_in;
    logic [CW-1:0] r_sidx;
    logic          r_inr;
    logic [CW-1:0] r_cur, r_before;
    logic          r_rej, r_resched;
    logic [7:0]    r_cp;
    logic [2:0]    r_curst;
    logic          r_any, r_found;
    logic [CW-1:0] r_best;
    logic [7:0]    r_pbest;
    logic          r_seen, r_hwake, r_htop, r_hfirst, r_hafter;
    logic [47:0]   r_mindl;
    logic [CW-1:0] r_top, r_first, r_after;
    logic [7:0]    r_ptop;
    logic [1:0]    r_nrun;
    logic [47:0]   r_qend;
    logic [22:0]   r_quantum;
    logic          r_idle;
    logic          r_done;
    t_sched_out    r_out;

    t_slot_rec w_head, n_h;
    logic      w_shift, w_hit, w_cur, w_last, n_rej;

    prrts_ring #(.THREADS(THREADS)) u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (w_shift),
        .i_tail  (n_h),
        .o_head  (w_head)
    );

    assign w_shift = (r_state == S_PA) || (r_state == S_PB) || (r_state == S_PR);
    assign w_hit   = r_inr && (r_idx == r_sidx);
    assign w_cur   = (r_idx == r_cur);
    assign w_last  = (r_idx == LAST);

    // edit of the slot at the head during each pass
    always_comb begin
        n_h   = w_head;
        n_rej = r_rej;
        unique case (r_state)
            S_PA: begin
                case (r_in.command)
                    CMD_ADD: if (w_hit) begin
                        if (w_head.valid) n_rej = 1'b1;
                        else begin
                            n_h.valid = 1'b1;
                            n_h.st    = ST_RUN;
                            n_h.prio  = r_in.priority_req;
                        end
                    end
                    CMD_REMOVE: if (w_hit && !r_rej) begin
                        if (!w_head.valid) n_rej = 1'b1;
                        else begin
                            n_h.valid = 1'b0;
                            n_h.st    = ST_STOP;
                        end
                    end
                    CMD_SETPRIO: if (w_hit) begin
                        if (!w_head.valid) n_rej = 1'b1;
                        else n_h.prio = r_in.priority_req;
                    end
                    CMD_WAIT: if (w_cur && !r_rej) begin
                        if (w_head.st != ST_RUN) n_rej = 1'b1;
                        else begin
                            n_h.st  = r_in.timed ? ST_TWAIT : ST_WAIT;
                            n_h.obj = r_in.wait_object;
                            if (r_in.timed) n_h.dl = r_in.deadline;
                        end
                    end
                    CMD_WAKEALL: begin
                        if (w_head.valid && (w_head.st == ST_WAIT || w_head.st == ST_TWAIT)
                            && w_head.obj == r_in.wait_object)
                            n_h.st = ST_RUN;
                    end
                    CMD_YIELD: if (w_hit) begin
                        if (!w_head.valid || w_head.st == ST_STOP) n_rej = 1'b1;
                        else n_h.st = ST_RUN;
                    end
                    default: ;
                endcase
            end
            S_PB: if (r_idx == r_best) n_h.st = ST_RUN;
            S_PR: begin
                if (w_head.valid && w_head.st == ST_TWAIT && !(w_head.dl > r_in.now))
                    n_h.st = ST_RUN;
            end
            S_IDLE, S_ACT, S_CHK, S_DEC, S_TIM: ;
            default: ;
        endcase
    end

    logic [47:0] w_base, w_qd, w_t1;
    always_comb begin
        w_base = r_hwake ? (r_mindl - r_in.now) : NO_WAKE_USEC;
        w_qd   = r_qend - r_in.now;
        w_t1   = ((r_qend > r_in.now) && (w_qd < w_base)) ? w_qd : w_base;
        if (w_t1 < TIMER_MIN) w_t1 = TIMER_MIN;
        if (w_t1 > TIMER_MAX) w_t1 = TIMER_MAX;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_idx     <= '0;
            r_cur     <= '0;
            r_qend    <= 48'd0;
            r_quantum <= QUANTUM_RESET;
            r_done    <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cfg_we) r_quantum <= i_cfg_wdata;
            unique case (r_state)
                S_IDLE: if (i_start) begin
                    r_in     <= i_cmd;
                    r_sidx   <= CW'(i_cmd.slot);
                    r_inr    <= 32'(i_cmd.slot) < 32'(THREADS);
                    r_before <= r_cur;
                    r_rej    <= 1'b0;
                    case (i_cmd.command)
                        CMD_ADD, CMD_SETPRIO, CMD_YIELD:
                            r_rej <= !(32'(i_cmd.slot) < 32'(THREADS));
                        CMD_REMOVE:
                            r_rej <= !(32'(i_cmd.slot) < 32'(THREADS))
                                     || (CW'(i_cmd.slot) == r_cur);
                        CMD_WAIT:
                            r_rej <= i_cmd.timed && !(i_cmd.deadline > i_cmd.now);
                        default: ;
                    endcase
                    r_any    <= 1'b0;
                    r_found  <= 1'b0;
                    r_idx    <= '0;
                    r_state  <= S_PA;
                end
                S_PA: begin
                    r_rej <= n_rej;
                    if (r_in.command == CMD_WAKEALL && n_h.st != w_head.st) r_any <= 1'b1;
                    if (r_in.command == CMD_WAKE1 && w_head.valid
                        && (w_head.st == ST_WAIT || w_head.st == ST_TWAIT)
                        && w_head.obj == r_in.wait_object
                        && (!r_found || w_head.prio > r_pbest)) begin
                        r_found <= 1'b1;
                        r_best  <= r_idx;
                        r_pbest <= w_head.prio;
                    end
                    if (w_cur) begin
                        r_cp    <= n_h.prio;
                        r_curst <= n_h.st;
                    end
                    r_idx <= w_last ? '0 : r_idx + 1'b1;
                    if (w_last) r_state <= S_ACT;
                end
                S_ACT: begin
                    r_resched <= 1'b0;
                    r_state   <= S_DEC;
                    if (!r_rej) begin
                        case (r_in.command)
                            CMD_ADD, CMD_SETPRIO, CMD_WAIT, CMD_TICK: begin
                                r_resched <= 1'b1;
                                r_state   <= S_PR;
                            end
                            CMD_WAKEALL: if (r_any) begin
                                r_resched <= 1'b1;
                                r_state   <= S_PR;
                            end
                            CMD_WAKE1: if (r_found) r_state <= S_PB;
                            CMD_YIELD: begin
                                r_cur   <= r_sidx;
                                r_curst <= ST_RUN;
                            end
                            default: ;
                        endcase
                    end
                    r_seen   <= 1'b0;
                    r_hwake  <= 1'b0;
                    r_htop   <= 1'b0;
                    r_hfirst <= 1'b0;
                    r_hafter <= 1'b0;
                    r_nrun   <= 2'd0;
                end
                S_PB: begin
                    if (w_cur && r_idx == r_best) r_curst <= ST_RUN;
                    r_idx <= w_last ? '0 : r_idx + 1'b1;
                    if (w_last) r_state <= S_CHK;
                end
                S_CHK: begin
                    if (r_pbest > r_cp || r_curst != ST_RUN) begin
                        r_resched <= 1'b1;
                        r_state   <= S_PR;
                    end else begin
                        r_state <= S_DEC;
                    end
                end
                S_PR: begin
                    if (w_head.valid) begin
                        if (w_cur) begin
                            r_seen  <= 1'b1;
                            r_curst <= n_h.st;
                        end
                        if (w_head.st == ST_TWAIT && w_head.dl > r_in.now) begin
                            if (!r_hwake || w_head.dl < r_mindl) begin
                                r_hwake <= 1'b1;
                                r_mindl <= w_head.dl;
                            end
                        end else if (n_h.st == ST_RUN) begin
                            if (!r_htop || w_head.prio > r_ptop) begin
                                r_htop <= 1'b1;
                                r_top  <= r_idx;
                                r_ptop <= w_head.prio;
                            end
                            if (w_head.prio == r_cp) begin
                                if (!w_cur) begin
                                    if (r_seen) begin
                                        if (!r_hafter) begin
                                            r_hafter <= 1'b1;
                                            r_after  <= r_idx;
                                        end
                                    end else if (!r_hfirst) begin
                                        r_hfirst <= 1'b1;
                                        r_first  <= r_idx;
                                    end
                                end
                                if (r_nrun != 2'd2) r_nrun <= r_nrun + 2'd1;
                            end
                        end
                    end
                    r_idx <= w_last ? '0 : r_idx + 1'b1;
                    if (w_last) r_state <= S_DEC;
                end
                S_DEC: begin
                    r_idle <= (r_curst != ST_RUN);
                    if (r_resched) begin
                        if (r_htop && r_ptop > r_cp) begin
                            r_cur  <= r_top;
                            r_idle <= (r_top == r_cur) ? (r_curst != ST_RUN) : 1'b0;
                        end else if (r_nrun == 2'd2 && !(r_in.now < r_qend)) begin
                            r_cur  <= r_hafter ? r_after : r_first;
                            r_idle <= 1'b0;
                            r_qend <= r_in.now + {25'd0, r_quantum};
                        end else if (r_curst != ST_RUN && r_htop) begin
                            r_cur  <= r_top;
                            r_idle <= 1'b0;
                        end
                    end
                    r_state <= S_TIM;
                end
                S_TIM: begin
                    r_out.current_thread <= 6'(r_cur);
                    r_out.switched       <= (r_cur != r_before);
                    r_out.idle           <= r_idle;
                    r_out.timer_usec     <= r_resched ? w_t1[22:0] : 23'd0;
                    r_out.status         <= r_rej;
                    r_done               <= 1'b1;
                    r_state              <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_res  = r_out;

endmodule

`default_nettype wire

FILE: tb/tb_priority_round_robin_thread_scheduler_top.sv
// Self-checking testbench for the priority round-robin thread scheduler.
// Depends on prrts_pkg and priority_round_robin_thread_scheduler_top.
// A scheduler model predicts each result beat; checked in order per field.
`timescale 1ns / 1ps

module tb_priority_round_robin_thread_scheduler_top;
    import prrts_pkg::*;

    localparam int          NSLOT     = 64;
    localparam int          WD_LIMIT  = 5000;
    localparam int          DRAIN_CYC = 3 * NSLOT + 16;
    localparam logic [47:0] T48_MAX   = 48'hFFFF_FFFF_FFFF;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    t_sched_in   cmd_beat = '0;
    logic        busy;
    logic        done;
    t_sched_out  res_beat;
    logic        cfg_we = 1'b0;
    logic [22:0] cfg_wdata = '0;

    // scheduler model state
    logic        m_valid [NSLOT];
    logic [2:0]  m_state [NSLOT];
    logic [7:0]  m_prio  [NSLOT];
    logic [31:0] m_obj   [NSLOT];
    logic [47:0] m_dl    [NSLOT];
    logic [5:0]  m_run;
    logic [47:0] m_qend;
    logic [22:0] m_quantum;

    t_sched_out  sched_due [$];
    int          mismatches = 0;
    int          idle_cycles = 0;
    int          burst_left = 0;
    logic [47:0] tnow = 48'd0;

    always #1 clk = ~clk;

    priority_round_robin_thread_scheduler_top #(.THREADS(NSLOT)) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_start     (start),
        .i_cmd       (cmd_beat),
        .o_busy      (busy),
        .o_done      (done),
        .o_res       (res_beat),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    task automatic report(input string what);
        $display("MISMATCH @%0t: %s", $realtime, what);
        mismatches++;
    endtask

    task automatic model_reset();
        for (int i = 0; i < NSLOT; i++) begin
            m_valid[i] = 1'b0;
            m_state[i] = ST_STOP;
            m_prio[i]  = 8'd0;
            m_obj[i]   = 32'd0;
            m_dl[i]    = 48'd0;
        end
        m_valid[0] = 1'b1;
        m_state[0] = ST_RUN;
        m_run      = 6'd0;
        m_qend     = 48'd0;
        m_quantum  = QUANTUM_RESET;
    endtask

    function automatic logic [47:0] resched(input logic [47:0] now);
        logic [5:0]  cur, nxt, wake, top, first, after;
        logic [7:0]  cp;
        logic        have_wake, have_top, seen_cur, have_first, have_after;
        logic [2:0]  st;
        int          numrun;
        logic [47:0] ival;
        cur = m_run; cp = m_prio[cur]; nxt = cur;
        have_wake = 0; have_top = 0; seen_cur = 0; have_first = 0; have_after = 0;
        wake = 0; top = 0; first = 0; after = 0; numrun = 0;
        for (int i = 0; i < NSLOT; i++) begin
            if (m_valid[i]) begin
                if (i == cur) seen_cur = 1;
                st = m_state[i];
                if (st == ST_TWAIT) begin
                    if (m_dl[i] > now) begin
                        if (!have_wake || m_dl[i] < m_dl[wake]) begin
                            wake = 6'(i); have_wake = 1;
                        end
                    end else begin
                        m_state[i] = ST_RUN;
                        st = ST_RUN;
                    end
                end
                if (st == ST_RUN) begin
                    if (!have_top || m_prio[i] > m_prio[top]) begin
                        top = 6'(i); have_top = 1;
                    end
                    if (m_prio[i] == cp) begin
                        if (i != cur) begin
                            if (seen_cur) begin
                                if (!have_after) begin after = 6'(i); have_after = 1; end
                            end else if (!have_first) begin
                                first = 6'(i); have_first = 1;
                            end
                        end
                        numrun++;
                    end
                end
            end
        end
        if (have_top && m_prio[top] > cp) begin
            nxt = top;
        end else if (numrun > 1 && now >= m_qend) begin
            nxt = have_after ? after : first;
            m_qend = now + 48'(m_quantum);
        end else if (m_state[cur] != ST_RUN) begin
            if (have_top) nxt = top;
        end
        ival = have_wake ? m_dl[wake] - now : NO_WAKE_USEC;
        if (m_qend > now && m_qend - now < ival) ival = m_qend - now;
        if (ival < TIMER_MIN) ival = TIMER_MIN;
        if (ival > TIMER_MAX) ival = TIMER_MAX;
        m_run = nxt;
        return ival;
    endfunction

    function automatic t_sched_out sched_predict(input t_sched_in c);
        t_sched_out  r;
        logic [5:0]  s, cur, prev_run, best;
        logic        rej, any, found;
        logic [47:0] tmr;
        s = c.slot; cur = m_run; prev_run = m_run;
        rej = 0; tmr = '0; any = 0; found = 0; best = 0;
        case (c.command)
            CMD_ADD: begin
                if (m_valid[s]) rej = 1;
                else begin
                    m_valid[s] = 1; m_state[s] = ST_RUN; m_prio[s] = c.priority_req;
                    tmr = resched(c.now);
                end
            end
            CMD_REMOVE: begin
                if (!m_valid[s] || s == cur) rej = 1;
                else begin
                    m_valid[s] = 0; m_state[s] = ST_STOP;
                end
            end
            CMD_SETPRIO: begin
                if (!m_valid[s]) rej = 1;
                else begin
                    m_prio[s] = c.priority_req;
                    tmr = resched(c.now);
                end
            end
            CMD_WAIT: begin
                if (m_state[cur] != ST_RUN || (c.timed && c.deadline <= c.now)) rej = 1;
                else begin
                    m_state[cur] = c.timed ? ST_TWAIT : ST_WAIT;
                    m_obj[cur] = c.wait_object;
                    if (c.timed) m_dl[cur] = c.deadline;
                    tmr = resched(c.now);
                end
            end
            CMD_WAKEALL: begin
                for (int i = 0; i < NSLOT; i++)
                    if (m_valid[i] && (m_state[i] == ST_WAIT || m_state[i] == ST_TWAIT)
                        && m_obj[i] == c.wait_object) begin
                        m_state[i] = ST_RUN; any = 1;
                    end
                if (any) tmr = resched(c.now);
            end
            CMD_WAKE1: begin
                for (int i = 0; i < NSLOT; i++)
                    if (m_valid[i] && (m_state[i] == ST_WAIT || m_state[i] == ST_TWAIT)
                        && m_obj[i] == c.wait_object
                        && (!found || m_prio[i] > m_prio[best])) begin
                        best = 6'(i); found = 1;
                    end
                if (found) begin
                    m_state[best] = ST_RUN;
                    if (m_prio[best] > m_prio[cur] || m_state[cur] != ST_RUN)
                        tmr = resched(c.now);
                end
            end
            CMD_TICK: tmr = resched(c.now);
            CMD_YIELD: begin
                if (!m_valid[s] || m_state[s] == ST_STOP) rej = 1;
                else begin
                    m_state[s] = ST_RUN; m_run = s;
                end
            end
            default: rej = 1;
        endcase
        r.current_thread = m_run;
        r.switched       = (m_run != prev_run);
        r.idle           = (m_state[m_run] != ST_RUN);
        r.timer_usec     = tmr[22:0];
        r.status         = rej;
        return r;
    endfunction

    // result checker: every done beat against the oldest prediction
    always @(posedge clk) begin
        t_sched_out exp_r;
        if (rst_n && done) begin
            if (sched_due.size() == 0) begin
                report("result beat with nothing expected");
            end else begin
                exp_r = sched_due.pop_front();
                if (res_beat.current_thread !== exp_r.current_thread)
                    report($sformatf("current_thread %0d exp %0d",
                                     res_beat.current_thread, exp_r.current_thread));
                if (res_beat.switched !== exp_r.switched)
                    report($sformatf("switched %b exp %b", res_beat.switched, exp_r.switched));
                if (res_beat.idle !== exp_r.idle)
                    report($sformatf("idle %b exp %b", res_beat.idle, exp_r.idle));
                if (res_beat.timer_usec !== exp_r.timer_usec)
                    report($sformatf("timer_usec %0d exp %0d",
                                     res_beat.timer_usec, exp_r.timer_usec));
                if (res_beat.status !== exp_r.status)
                    report($sformatf("status %b exp %b", res_beat.status, exp_r.status));
            end
        end
    end

    // watchdog on cycles with no beat moving either way
    always @(posedge clk) begin
        if (!rst_n || done || (start && !busy)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic send_cmd(input t_sched_in c);
        int gap;
        start    <= 1'b1;
        cmd_beat <= c;
        do @(posedge clk); while (busy);
        sched_due.push_back(sched_predict(c));
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 16);
            if ($urandom_range(0, 4) != 0) begin
                gap = $urandom_range(1, 20);
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (sched_due.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_quantum(input logic [22:0] q);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= q;
        @(posedge clk);
        cfg_we    <= 1'b0;
        m_quantum = q;
        @(posedge clk);
    endtask

    function automatic t_sched_in mk(input logic [2:0] op, input logic [5:0] s,
                                     input logic [7:0] p, input logic [31:0] o,
                                     input logic tm, input logic [47:0] dl,
                                     input logic [47:0] now);
        t_sched_in c;
        c.command = op; c.slot = s; c.priority_req = p; c.wait_object = o;
        c.timed = tm; c.deadline = dl; c.now = now;
        return c;
    endfunction

    function automatic logic [47:0] rand48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    task automatic test_directed();
        write_quantum(23'd1);
        send_cmd(mk(CMD_ADD, 6'd1, 8'd0, '0, 0, '0, 48'd100));
        send_cmd(mk(CMD_TICK, 6'd0, 8'd0, '0, 0, '0, 48'd200));   // equal prio rotate
        send_cmd(mk(CMD_ADD, 6'd1, 8'd9, '0, 0, '0, 48'd210));    // duplicate slot
        send_cmd(mk(CMD_ADD, 6'd63, 8'd255, '1, 1, T48_MAX, 48'd220)); // preempt
        send_cmd(mk(CMD_REMOVE, 6'd63, 8'd0, '0, 0, '0, 48'd230)); // running: reject
        send_cmd(mk(CMD_REMOVE, 6'd40, 8'd0, '0, 0, '0, 48'd230)); // invalid
        send_cmd(mk(CMD_WAIT, 6'd0, 8'd0, 32'hFFFF_FFFF, 1, 48'd240, 48'd240)); // past
        send_cmd(mk(CMD_WAIT, 6'd0, 8'd0, 32'hFFFF_FFFF, 0, '0, 48'd250));
        send_cmd(mk(CMD_SETPRIO, 6'd1, 8'd255, '0, 0, '0, 48'd260));
        send_cmd(mk(CMD_WAIT, 6'd0, 8'd0, 32'd0, 1, 48'd400, 48'd270));  // timed sleep
        send_cmd(mk(CMD_WAIT, 6'd0, 8'd0, 32'd0, 1, 48'd600, 48'd280));
        send_cmd(mk(CMD_TICK, 6'd0, 8'd0, '0, 0, '0, 48'd300));          // idle
        send_cmd(mk(CMD_TICK, 6'd0, 8'd0, '0, 0, '0, 48'd500));          // expiry
        send_cmd(mk(CMD_WAKE1, 6'd0, 8'd0, 32'hFFFF_FFFF, 0, '0, 48'd510));
        send_cmd(mk(CMD_WAKEALL, 6'd0, 8'd0, 32'd7, 0, '0, 48'd520));   // nobody
        send_cmd(mk(CMD_YIELD, 6'd20, 8'd0, '0, 0, '0, 48'd530));       // stopped
        send_cmd(mk(CMD_YIELD, 6'd0, 8'd0, '0, 0, '0, 48'd540));
        send_cmd(mk(CMD_REMOVE, 6'd63, 8'd0, '0, 0, '0, 48'd550));
        write_quantum(23'd4194304);
        send_cmd(mk(CMD_SETPRIO, 6'd1, 8'd0, '0, 0, '0, T48_MAX - 48'd5));  // wrap
        send_cmd(mk(CMD_TICK, 6'd0, 8'd0, '0, 0, '0, T48_MAX));
        send_cmd(mk(CMD_WAKEALL, 6'd0, 8'd0, 32'd0, 0, '0, T48_MAX));
        drain();
    endtask

    function automatic t_sched_in rand_cmd();
        t_sched_in c;
        int        pick;
        pick = $urandom_range(0, 99);
        c.command = pick < 15 ? CMD_ADD : pick < 25 ? CMD_REMOVE : pick < 35 ? CMD_SETPRIO :
                    pick < 55 ? CMD_WAIT : pick < 65 ? CMD_WAKEALL : pick < 80 ? CMD_WAKE1 :
                    pick < 95 ? CMD_TICK : CMD_YIELD;
        c.slot = $urandom_range(0, 9) < 7 ? 6'($urandom_range(0, 7)) : 6'($urandom);
        case ($urandom_range(0, 5))
            0: c.priority_req = 8'd0;
            1: c.priority_req = 8'd255;
            2, 3: c.priority_req = 8'($urandom_range(1, 3));
            default: c.priority_req = 8'($urandom);
        endcase
        c.wait_object = $urandom_range(0, 9) < 8 ? 32'($urandom_range(0, 3)) : 32'($urandom);
        c.timed = 1'($urandom_range(0, 1));
        tnow += 48'($urandom_range(0, 3000));
        c.now = ($urandom_range(0, 49) == 0) ? rand48() : tnow;
        c.deadline = ($urandom_range(0, 9) == 0) ? rand48()
                                                 : c.now + 48'($urandom_range(1, 40000));
        return c;
    endfunction

    task automatic test_random(input int n, input logic [22:0] q);
        write_quantum(q);
        for (int i = 0; i < n; i++) begin
            send_cmd(rand_cmd());
            if (i == n / 2) drain();   // hold off until every result is back
        end
    endtask

    initial begin
        model_reset();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(400, 23'd10000);
        test_random(400, 23'd1);
        test_random(400, 23'd4194304);
        test_random(400, 23'($urandom_range(1, 4194304)));
        test_random(350, 23'd500);
        drain();
        repeat (DRAIN_CYC) @(posedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
